// File: src/assert_macros.svh
// Assertion macros shared by the RTL files.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: src/rmq_pkg.sv
// Package for the rotation matrix to quaternion converter.
// Constants, widths and the branch code type. No dependencies.
`default_nettype none
package rmq_pkg;
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 30;
	localparam int THR_BITS = 31;
	localparam logic [THR_BITS-1:0] THRESH_RESET = 31'd1073742;

	typedef enum logic [3:0] {
		BR_DIRECT = 4'b0001,
		BR_X      = 4'b0010,
		BR_Y      = 4'b0100,
		BR_Z      = 4'b1000
	} branch_t;
endpackage
`default_nettype wire

// File: src/rmq_sqrt_cell.sv
// One step of the digit-by-digit square root, a cell of the chain.
// Depends on nothing but its parameters.
`default_nettype none
module rmq_sqrt_cell #(
	parameter int RW = 64,
	parameter int STEP = 0
) (
	input  wire logic [RW-1:0] rem_i,
	input  wire logic [RW-1:0] res_i,
	output logic      [RW-1:0] rem_o,
	output logic      [RW-1:0] res_o
);
	localparam int SH = RW - 2 - 2 * STEP;
	logic [RW-1:0] bitv;
	logic [RW-1:0] trial;
	always_comb begin
		bitv = {{(RW-1){1'b0}}, 1'b1} << SH;
		trial = res_i + bitv;
		if (rem_i >= trial) begin
			rem_o = rem_i - trial;
			res_o = (res_i >> 1) + bitv;
		end else begin
			rem_o = rem_i;
			res_o = res_i >> 1;
		end
	end
endmodule
`default_nettype wire

// File: src/rmq_div_cell.sv
// One restoring division step for three quotients sharing a divisor.
// Depends on nothing but its parameters.
`default_nettype none
module rmq_div_cell #(
	parameter int NW = 96
) (
	input  wire logic [NW-1:0]     den_i,
	input  wire logic [2:0][NW-1:0] rem_i,
	input  wire logic [2:0][NW-1:0] num_i,
	input  wire logic [2:0][NW-1:0] q_i,
	output logic      [2:0][NW-1:0] rem_o,
	output logic      [2:0][NW-1:0] num_o,
	output logic      [2:0][NW-1:0] q_o
);
	logic [NW-1:0] t;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t = {rem_i[k][NW-2:0], num_i[k][NW-1]};
			num_o[k] = {num_i[k][NW-2:0], 1'b0};
			if (t >= den_i) begin
				rem_o[k] = t - den_i;
				q_o[k] = {q_i[k][NW-2:0], 1'b1};
			end else begin
				rem_o[k] = t;
				q_o[k] = {q_i[k][NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// File: src/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to quaternion converter.
// Pipeline: registered front end, one sqrt cell per result bit, one division cell
// per quotient bit, rounding; one item per cycle throughput unless stalled,
// set by the chain of registered root and divide cells with a stall on tready.
// Reset (arst_n low) clears valid bits and loads the threshold default.
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_top #(
	parameter int WORD_BITS = rmq_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [rmq_pkg::THR_BITS-1:0] cfg_wdata,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// m00,m01,m02,m10,m11,m12,m20,m21,m22 from bit 0 up
	input  wire logic [9*WORD_BITS-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// quat_w,quat_x,quat_y,quat_z from bit 0 up
	output logic [4*WORD_BITS-1:0] m_tdata,
	// degenerate
	output logic m_tuser
);
	localparam int RW = 2 * WORD_BITS + 2;        // radicand << FRAC
	localparam int SQ = RW / 2;                   // root steps
	localparam int NW = WORD_BITS + 4 + FRAC_BITS; // dividend width
	localparam int XW = WORD_BITS + 4;            // extended sums

	logic [rmq_pkg::THR_BITS-1:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= rmq_pkg::THRESH_RESET;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	// global stall: chain advances when output slot is free or taken
	logic adv;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: extended entries
	logic v_s1;
	logic signed [XW-1:0] a_s1 [9];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (adv) for (int i = 0; i < 9; i++)
			a_s1[i] <= XW'($signed(s_tdata[i*WORD_BITS +: WORD_BITS]));
	end

	// stage 2: branch, radicand, numerators
	logic signed [XW-1:0] one_c;
	assign one_c = XW'(1) <<< FRAC_BITS;
	logic signed [XW-1:0] rd, rb, n0, n1, n2;
	rmq_pkg::branch_t br;
	logic xs, ys;
	always_comb begin
		rd = one_c + a_s1[0] + a_s1[4] + a_s1[8];
		xs = (a_s1[0] > a_s1[4]) && (a_s1[0] > a_s1[8]);
		ys = a_s1[4] > a_s1[8];
		if (rd > 0 && rd > $signed({{(XW-rmq_pkg::THR_BITS){1'b0}}, thr_q})) begin
			br = rmq_pkg::BR_DIRECT; rb = rd;
			n0 = a_s1[7] - a_s1[5]; n1 = a_s1[2] - a_s1[6]; n2 = a_s1[3] - a_s1[1];
		end else if (xs) begin
			br = rmq_pkg::BR_X; rb = one_c + a_s1[0] - a_s1[4] - a_s1[8];
			n0 = a_s1[7] - a_s1[5]; n1 = a_s1[1] + a_s1[3]; n2 = a_s1[2] + a_s1[6];
		end else if (ys) begin
			br = rmq_pkg::BR_Y; rb = one_c - a_s1[0] + a_s1[4] - a_s1[8];
			n0 = a_s1[2] - a_s1[6]; n1 = a_s1[1] + a_s1[3]; n2 = a_s1[5] + a_s1[7];
		end else begin
			br = rmq_pkg::BR_Z; rb = one_c - a_s1[0] - a_s1[4] + a_s1[8];
			n0 = a_s1[3] - a_s1[1]; n1 = a_s1[2] + a_s1[6]; n2 = a_s1[5] + a_s1[7];
		end
	end

	typedef struct packed {
		logic dg;
		rmq_pkg::branch_t br;
		logic [2:0] neg;
		logic [2:0][XW-1:0] mag;
	} ctl_t;

	function automatic logic [XW-1:0] absx(input logic signed [XW-1:0] v);
		absx = v[XW-1] ? XW'(-v) : XW'(v);
	endfunction

	logic v_sq [SQ+1];
	ctl_t c_sq [SQ+1];
	logic [RW-1:0] rem_sq [SQ+1];
	logic [RW-1:0] res_sq [SQ+1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sq[0] <= 1'b0;
		else if (adv) v_sq[0] <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			c_sq[0].dg <= (rb <= 0);
			c_sq[0].br <= br;
			c_sq[0].neg <= {n2[XW-1], n1[XW-1], n0[XW-1]};
			c_sq[0].mag <= {absx(n2), absx(n1), absx(n0)};
			rem_sq[0] <= (rb <= 0) ? '0 : RW'(unsigned'(rb)) << FRAC_BITS;
			res_sq[0] <= '0;
		end
	end

	for (genvar g = 0; g < SQ; g++) begin : g_sq
		logic [RW-1:0] rn, sn;
		rmq_sqrt_cell #(.RW(RW), .STEP(g)) u_c (
			.rem_i(rem_sq[g]), .res_i(res_sq[g]), .rem_o(rn), .res_o(sn));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sq[g+1] <= 1'b0;
			else if (adv) v_sq[g+1] <= v_sq[g];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				c_sq[g+1] <= c_sq[g];
				rem_sq[g+1] <= rn; res_sq[g+1] <= sn;
			end
		end
	end

	// division chain: den = 2*S
	logic v_dv [NW+1];
	ctl_t c_dv [NW+1];
	logic [NW-1:0] den_dv [NW+1];
	logic [NW-1:0] s_dv [NW+1];
	logic [2:0][NW-1:0] rem_dv [NW+1], num_dv [NW+1], q_dv [NW+1];
	assign v_dv[0] = v_sq[SQ];
	assign c_dv[0] = c_sq[SQ];
	assign s_dv[0] = NW'(res_sq[SQ]);
	assign den_dv[0] = NW'(res_sq[SQ]) << 1;
	assign rem_dv[0] = '0;
	assign q_dv[0] = '0;
	always_comb
		for (int k = 0; k < 3; k++)
			num_dv[0][k] = NW'(c_sq[SQ].mag[k]) << FRAC_BITS;

	for (genvar g = 0; g < NW; g++) begin : g_dv
		logic [2:0][NW-1:0] ro, no, qo;
		rmq_div_cell #(.NW(NW)) u_c (
			.den_i(den_dv[g]), .rem_i(rem_dv[g]), .num_i(num_dv[g]), .q_i(q_dv[g]),
			.rem_o(ro), .num_o(no), .q_o(qo));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_dv[g+1] <= 1'b0;
			else if (adv) v_dv[g+1] <= v_dv[g];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				c_dv[g+1] <= c_dv[g];
				den_dv[g+1] <= den_dv[g]; s_dv[g+1] <= s_dv[g];
				rem_dv[g+1] <= ro; num_dv[g+1] <= no; q_dv[g+1] <= qo;
			end
		end
	end

	// rounding, saturation, placement
	localparam logic [NW-1:0] MAXP = NW'({(WORD_BITS-1){1'b1}});
	function automatic logic [WORD_BITS-1:0] sat(input logic ng, input logic [NW-1:0] m);
		logic [NW-1:0] mm;
		mm = m;
		if (ng) begin
			if (mm > MAXP + 1) mm = MAXP + 1;
			sat = WORD_BITS'(~mm + 1'b1);
		end else begin
			if (mm > MAXP) mm = MAXP;
			sat = WORD_BITS'(mm);
		end
	endfunction

	logic [2:0][WORD_BITS-1:0] dq;
	logic [WORD_BITS-1:0] hr, qw, qx, qy, qz;
	ctl_t cl;
	logic [NW-1:0] dl;
	assign cl = c_dv[NW];
	assign dl = den_dv[NW];
	always_comb begin
		for (int k = 0; k < 3; k++)
			dq[k] = sat(cl.neg[k], q_dv[NW][k] +
				NW'(rem_dv[NW][k] >= dl - rem_dv[NW][k]));
		hr = sat(1'b0, (s_dv[NW] + 1'b1) >> 1);
		case (cl.br)
			rmq_pkg::BR_DIRECT: begin qw = hr; qx = dq[0]; qy = dq[1]; qz = dq[2]; end
			rmq_pkg::BR_X: begin qw = dq[0]; qx = hr; qy = dq[1]; qz = dq[2]; end
			rmq_pkg::BR_Y: begin qw = dq[0]; qx = dq[1]; qy = hr; qz = dq[2]; end
			default: begin qw = dq[0]; qx = dq[1]; qy = dq[2]; qz = hr; end
		endcase
		if (cl.dg) begin
			qw = sat(1'b0, NW'(1) << FRAC_BITS); qx = '0; qy = '0; qz = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (adv) m_tvalid <= v_dv[NW];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {qz, qy, qx, qw};
			m_tuser <= cl.dg;
		end
	end

	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`ASSERT_IMPLIES(a_ready, clk, arst_n, !m_tvalid, s_tready)
	`ASSERT_IMPLIES(a_degen, clk, arst_n, m_tvalid && m_tuser, m_tdata[4*WORD_BITS-1:WORD_BITS] == '0)
endmodule
`default_nettype wire

// File: dv/rotation_matrix_to_quaternion_top_test.sv
// Testbench for the rotation matrix to quaternion converter.
// Drives matrices over the stream input, predicts quaternions in place and checks
// each result item in order. Depends on rmq_pkg and rotation_matrix_to_quaternion_top.
`default_nettype none
module rotation_matrix_to_quaternion_top_test;
	localparam int WB = rmq_pkg::WORD_BITS_DEF;
	localparam int FB = rmq_pkg::FRAC_BITS_DEF;
	localparam int LAT = 4 + WB + (WB + 4 + FB);
	localparam int WATCHDOG = 20000;
	localparam longint ONE = 64'sd1 << FB;

	typedef logic signed [WB-1:0] word_t;
	typedef struct {
		word_t m[9];
	} matrix_t;
	typedef struct packed {
		word_t w, x, y, z;
		logic  degen;
	} quat_t;
	typedef struct {
		matrix_t mat;
		logic    typed;
		quat_t   q;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rmq_pkg::THR_BITS-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [9*WB-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [4*WB-1:0] m_tdata;
	logic m_tuser;

	rotation_matrix_to_quaternion_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [rmq_pkg::THR_BITS-1:0] threshold;
	quat_t pending_quats[$];
	int errors = 0;
	int idle_cycles = 0;
	bit sink_hold = 1'b0;
	bit calm = 1'b0;
	bit timed_out = 1'b0;

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic word_t clamp(bit neg, longint unsigned mag);
		longint unsigned maxpos;
		maxpos = (64'd1 << (WB - 1)) - 1;
		if (neg) begin
			if (mag > maxpos + 1)
				mag = maxpos + 1;
			return word_t'(-mag);
		end
		if (mag > maxpos)
			mag = maxpos;
		return word_t'(mag);
	endfunction

	// num / (2s), round half away from zero
	function automatic word_t scaled_ratio(longint num, longint unsigned s);
		bit neg;
		longint unsigned mag, den, n, q, r;
		neg = num < 0;
		mag = neg ? -num : num;
		den = s << 1;
		n = mag << FB;
		q = n / den;
		r = n % den;
		if (r >= den - r)
			q += 1;
		return clamp(neg, q);
	endfunction

	function automatic quat_t quat_of(matrix_t mt);
		longint a[9];
		longint rad;
		longint unsigned s;
		quat_t q;
		foreach (a[i])
			a[i] = longint'(mt.m[i]);
		q.degen = 1'b0;
		rad = ONE + a[0] + a[4] + a[8];
		if (rad > 0 && rad > longint'(threshold)) begin
			s = root_floor(rad << FB);
			q.w = clamp(1'b0, (s + 1) >> 1);
			q.x = scaled_ratio(a[7] - a[5], s);
			q.y = scaled_ratio(a[2] - a[6], s);
			q.z = scaled_ratio(a[3] - a[1], s);
			return q;
		end
		if (a[0] > a[4] && a[0] > a[8])
			rad = ONE + a[0] - a[4] - a[8];
		else if (a[4] > a[8])
			rad = ONE - a[0] + a[4] - a[8];
		else
			rad = ONE - a[0] - a[4] + a[8];
		if (rad <= 0) begin
			q.w = clamp(1'b0, ONE);
			q.x = '0;
			q.y = '0;
			q.z = '0;
			q.degen = 1'b1;
			return q;
		end
		s = root_floor(rad << FB);
		if (a[0] > a[4] && a[0] > a[8]) begin
			q.w = scaled_ratio(a[7] - a[5], s);
			q.x = clamp(1'b0, (s + 1) >> 1);
			q.y = scaled_ratio(a[1] + a[3], s);
			q.z = scaled_ratio(a[2] + a[6], s);
		end else if (a[4] > a[8]) begin
			q.w = scaled_ratio(a[2] - a[6], s);
			q.x = scaled_ratio(a[1] + a[3], s);
			q.y = clamp(1'b0, (s + 1) >> 1);
			q.z = scaled_ratio(a[5] + a[7], s);
		end else begin
			q.w = scaled_ratio(a[3] - a[1], s);
			q.x = scaled_ratio(a[2] + a[6], s);
			q.y = scaled_ratio(a[5] + a[7], s);
			q.z = clamp(1'b0, (s + 1) >> 1);
		end
		return q;
	endfunction

	// result side: check against oldest prediction
	always @(posedge clk) begin
		quat_t got, want;
		if (m_tvalid && m_tready) begin
			got.w = m_tdata[0 +: WB];
			got.x = m_tdata[WB +: WB];
			got.y = m_tdata[2*WB +: WB];
			got.z = m_tdata[3*WB +: WB];
			got.degen = m_tuser;
			if (pending_quats.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected item w=%h x=%h y=%h z=%h", got.w, got.x, got.y,
						got.z);
			end else begin
				want = pending_quats.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp w=%h x=%h y=%h z=%h d=%b got %h %h %h %h %b",
							want.w, want.x, want.y, want.z, want.degen,
							got.w, got.x, got.y, got.z, got.degen);
				end
			end
		end
		if (arst_n)
			m_tready <= sink_hold ? 1'b0 : (calm || $urandom_range(99) >= 19);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1'b1;
			$display("FAILURE");
			$finish;
		end
	end

	task automatic put_matrix(matrix_t mt, bit typed, quat_t q);
		logic [9*WB-1:0] flat;
		for (int i = 0; i < 9; i++)
			flat[i*WB +: WB] = mt.m[i];
		while (!calm && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= flat;
		do
			@(posedge clk);
		while (!s_tready);
		pending_quats.push_back(typed ? q : quat_of(mt));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_quats.size() != 0)
			@(posedge clk);
		repeat (LAT + 10) @(posedge clk);
	endtask

	task automatic set_threshold(logic [rmq_pkg::THR_BITS-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = v;
	endtask

	function automatic matrix_t diag(longint d0, longint d1, longint d2);
		matrix_t mt;
		foreach (mt.m[i])
			mt.m[i] = '0;
		mt.m[0] = word_t'(d0);
		mt.m[4] = word_t'(d1);
		mt.m[8] = word_t'(d2);
		return mt;
	endfunction

	function automatic matrix_t rand_matrix(bit wild);
		matrix_t mt;
		foreach (mt.m[i])
			mt.m[i] = wild ? word_t'($urandom) :
				word_t'($urandom_range(32'h8000_0000) - 32'h4000_0000);
		return mt;
	endfunction

	task automatic directed();
		stim_row_t rows[$];
		stim_row_t r;
		// identity rotation: direct branch, unit w
		r.typed = 1'b1;
		r.q = '{w: word_t'(ONE), x: '0, y: '0, z: '0, degen: 1'b0};
		r.mat = diag(ONE, ONE, ONE);
		rows.push_back(r);
		r.typed = 1'b0;
		// half-turns about each axis: x, y, z branches
		r.mat = diag(ONE, -ONE, -ONE);
		rows.push_back(r);
		r.mat = diag(-ONE, ONE, -ONE);
		rows.push_back(r);
		r.mat = diag(-ONE, -ONE, ONE);
		rows.push_back(r);
		// ties on the diagonal fall to the z branch
		r.mat = diag(-ONE, -ONE, -ONE);
		r.mat.m[1] = 32'sh7fffffff;
		r.mat.m[3] = 32'sh80000000;
		rows.push_back(r);
		// negative trace with tied lower entries
		r.mat = diag(-ONE, -ONE / 2, -ONE / 2);
		rows.push_back(r);
		r.mat = diag(32'sh80000000, 32'sh80000000, 32'sh80000000);
		rows.push_back(r);
		// field extremes, saturation of divided terms
		r.mat = diag(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		r.mat.m[7] = 32'sh7fffffff;
		r.mat.m[5] = 32'sh80000000;
		rows.push_back(r);
		r.mat = diag(-ONE + 2, 0, 0);
		r.mat.m[7] = 32'sh7fffffff;
		r.mat.m[5] = 32'sh80000000;
		r.mat.m[2] = 32'sh80000000;
		r.mat.m[6] = 32'sh7fffffff;
		rows.push_back(r);
		// every entry one lsb below zero
		r.mat = diag(0, 0, 0);
		foreach (r.mat.m[i])
			r.mat.m[i] = -32'sh1;
		rows.push_back(r);
		// one plus trace exactly at the reset threshold, and one above
		r.mat = diag(-ONE + 1073742, 0, 0);
		rows.push_back(r);
		r.mat = diag(-ONE + 1073743, 0, 0);
		rows.push_back(r);
		foreach (rows[i])
			put_matrix(rows[i].mat, rows[i].typed, rows[i].q);
	endtask

	task automatic random_phase(int count);
		quat_t none;
		for (int i = 0; i < count; i++)
			put_matrix(rand_matrix($urandom_range(3) == 0), 1'b0, none);
	endtask

	initial begin
		threshold = rmq_pkg::THRESH_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		set_threshold('0);
		random_phase(100);
		set_threshold(31'h40000000);
		random_phase(100);
		// receiver blocked long enough to back the pipeline up
		sink_hold = 1'b1;
		calm = 1'b1;
		fork
			begin
				repeat (LAT * 3) @(posedge clk);
				sink_hold = 1'b0;
			end
			random_phase(LAT + 20);
		join
		calm = 1'b0;
		drain();
		set_threshold(31'd12345);
		calm = 1'b1;
		random_phase(80);
		calm = 1'b0;
		set_threshold(rmq_pkg::THRESH_RESET);
		random_phase(140);
		drain();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
